FILE: hw/rtl/pump_safety_interlock_core_defines.svh
// assertion macros for the pump safety interlock
`ifndef PUMP_SAFETY_INTERLOCK_CORE_DEFINES_SVH
`define PUMP_SAFETY_INTERLOCK_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define PSI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/psi_pkg.sv
// shared types, constants and helpers for the pump safety interlock
`timescale 1ns / 1ps

package psi_pkg;

   localparam int CNT_W     = 27;
   localparam int DEG_W     = 8;
   localparam int REQ_DEG_W = 11;
   localparam int EVT_W     = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] WATCHDOG_RESET = CNT_W'(30000);
   localparam logic [CNT_W-1:0] RUNTIME_RESET  = CNT_W'(600000);
   localparam logic [DEG_W-1:0] SERVO_MIN_RESET = DEG_W'(0);
   localparam logic [DEG_W-1:0] SERVO_MAX_RESET = DEG_W'(180);

   typedef enum logic [EVT_W-1:0] {
      EV_NONE     = 3'd0,
      EV_APPLIED  = 3'd1,
      EV_REJECTED = 3'd2,
      EV_WATCHDOG = 3'd3,
      EV_RUNTIME  = 3'd4
   } psi_event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WATCHDOG_LIMIT = 2'd0,
      CSR_MAX_RUNTIME    = 2'd1,
      CSR_SERVO_MIN      = 2'd2,
      CSR_SERVO_MAX      = 2'd3
   } psi_csr_index_type;

   typedef struct packed {
      logic [CNT_W-1:0] watchdog_limit;
      logic [CNT_W-1:0] max_runtime;
      logic [DEG_W-1:0] servo_min;
      logic [DEG_W-1:0] servo_max;
   } psi_cfg_type;

   typedef struct packed {
      logic                        command;
      logic                        has_first_pump;
      logic                        first_pump_request;
      logic                        has_second_pump;
      logic                        second_pump_request;
      logic                        has_servo;
      logic signed [REQ_DEG_W-1:0] servo_request_deg;
   } psi_item_type;

   typedef struct packed {
      logic             first_pump;
      logic             second_pump;
      logic [CNT_W-1:0] silence_count;
      logic [CNT_W-1:0] run_count;
      logic             lockout;
      logic [DEG_W-1:0] servo_angle;
   } psi_state_type;

   // counter that sticks at all ones
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (&v) ? v : v + CNT_W'(1);
   endfunction

endpackage

FILE: hw/rtl/psi_csr.sv
// configuration register file of the pump safety interlock
`timescale 1ns / 1ps

module psi_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [psi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [psi_pkg::CNT_W-1:0]     csr_wdata,
   output psi_pkg::psi_cfg_type          cfg
);
   import psi_pkg::*;

   psi_cfg_type cfg_ff;
   psi_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (psi_csr_index_type'(csr_index))
            CSR_WATCHDOG_LIMIT: cfg_in.watchdog_limit = csr_wdata;
            CSR_MAX_RUNTIME:    cfg_in.max_runtime    = csr_wdata;
            CSR_SERVO_MIN:      cfg_in.servo_min      = csr_wdata[DEG_W-1:0];
            CSR_SERVO_MAX:      cfg_in.servo_max      = csr_wdata[DEG_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.watchdog_limit <= WATCHDOG_RESET;
         cfg_ff.max_runtime    <= RUNTIME_RESET;
         cfg_ff.servo_min      <= SERVO_MIN_RESET;
         cfg_ff.servo_max      <= SERVO_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/psi_step.sv
// next-state and event logic for one tick or command
`timescale 1ns / 1ps

module psi_step (
   input  psi_pkg::psi_cfg_type   cfg,
   input  psi_pkg::psi_state_type cur,
   input  psi_pkg::psi_item_type  item,
   output psi_pkg::psi_state_type nxt,
   output psi_pkg::psi_event_type evt
);
   import psi_pkg::*;

   logic                        want_on;
   logic                        was_running;
   logic signed [REQ_DEG_W:0]   deg_x;
   logic signed [REQ_DEG_W:0]   min_x;
   logic signed [REQ_DEG_W:0]   max_x;

   always_comb begin
      nxt         = cur;
      evt         = EV_NONE;
      want_on     = (item.has_first_pump && item.first_pump_request) ||
                    (item.has_second_pump && item.second_pump_request);
      was_running = 1'b0;
      deg_x       = {item.servo_request_deg[REQ_DEG_W-1], item.servo_request_deg};
      min_x       = $signed({{(REQ_DEG_W+1-DEG_W){1'b0}}, cfg.servo_min});
      max_x       = $signed({{(REQ_DEG_W+1-DEG_W){1'b0}}, cfg.servo_max});

      if (item.command) begin
         nxt.silence_count = '0;
         if (cur.lockout && want_on) begin
            evt = EV_REJECTED;
         end else begin
            // pumps are set one after the other, run count follows each step
            if (item.has_first_pump) begin
               was_running    = nxt.first_pump || nxt.second_pump;
               nxt.first_pump = item.first_pump_request;
               if ((item.first_pump_request && !was_running) ||
                   (!nxt.first_pump && !nxt.second_pump)) begin
                  nxt.run_count = '0;
               end
            end
            if (item.has_second_pump) begin
               was_running     = nxt.first_pump || nxt.second_pump;
               nxt.second_pump = item.second_pump_request;
               if ((item.second_pump_request && !was_running) ||
                   (!nxt.first_pump && !nxt.second_pump)) begin
                  nxt.run_count = '0;
               end
            end
            if (item.has_servo) begin
               if (deg_x < min_x) begin
                  nxt.servo_angle = cfg.servo_min;
               end else if (deg_x > max_x) begin
                  nxt.servo_angle = cfg.servo_max;
               end else begin
                  nxt.servo_angle = item.servo_request_deg[DEG_W-1:0];
               end
            end
            evt = EV_APPLIED;
         end
      end else begin
         nxt.silence_count = sat_inc(cur.silence_count);
         if (cur.first_pump || cur.second_pump) begin
            nxt.run_count = sat_inc(cur.run_count);
         end
         // watchdog first; it leaves nothing running for the runtime check
         if ((cur.first_pump || cur.second_pump) &&
             (nxt.silence_count > cfg.watchdog_limit)) begin
            nxt.first_pump  = 1'b0;
            nxt.second_pump = 1'b0;
            nxt.run_count   = '0;
            evt             = EV_WATCHDOG;
         end else if ((cur.first_pump || cur.second_pump) &&
                      (nxt.run_count > cfg.max_runtime)) begin
            nxt.first_pump  = 1'b0;
            nxt.second_pump = 1'b0;
            nxt.run_count   = '0;
            nxt.lockout     = 1'b1;
            evt             = EV_RUNTIME;
         end
      end
   end

endmodule

FILE: hw/rtl/pump_safety_interlock_core.sv
// top level of the pump safety interlock: beat registers, state and csr
`timescale 1ns / 1ps

`include "pump_safety_interlock_core_defines.svh"

// Pump safety interlock. Each request beat is a one millisecond tick
// (command low) or a control command, and gives exactly one response beat
// with the pump drives, clamped servo angle, lockout flag and an event code.
// A beat is taken every cycle when the response side keeps up; each request
// is held in the input register, then goes through one pass of the state
// update into the response register. The rate of one beat per cycle rests
// on the pump, counter and lockout state being updated in that one pass.
// Configuration writes are always ready and should only be made while no
// beat is in flight. The lockout is cleared by reset alone.
module pump_safety_interlock_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_command,
   input  logic                                  req_has_first_pump,
   input  logic                                  req_first_pump_request,
   input  logic                                  req_has_second_pump,
   input  logic                                  req_second_pump_request,
   input  logic                                  req_has_servo,
   input  logic signed [psi_pkg::REQ_DEG_W-1:0]  req_servo_request_deg,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_first_pump_on,
   output logic                                  rsp_second_pump_on,
   output logic [psi_pkg::DEG_W-1:0]             rsp_servo_angle_deg,
   output logic                                  rsp_lockout_active,
   output logic [psi_pkg::EVT_W-1:0]             rsp_event_code,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [psi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [psi_pkg::CNT_W-1:0]             csr_wdata
);
   import psi_pkg::*;

   psi_cfg_type   cfg;
   psi_item_type  item_ff;
   psi_item_type  item_in;
   logic          in_valid_ff;
   logic          in_valid_in;
   psi_state_type state_ff;
   psi_state_type state_in;
   psi_state_type step_nxt;
   psi_event_type step_evt;
   logic          out_valid_ff;
   logic          out_valid_in;
   psi_state_type out_state_ff;
   psi_state_type out_state_in;
   psi_event_type out_evt_ff;
   psi_event_type out_evt_in;
   logic          advance;
   logic          req_take;

   psi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   psi_step u_step (
      .cfg  (cfg),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (step_nxt),
      .evt  (step_evt)
   );

   // held beat moves on when the response register is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_in.command             = req_command;
      item_in.has_first_pump      = req_has_first_pump;
      item_in.first_pump_request  = req_first_pump_request;
      item_in.has_second_pump     = req_has_second_pump;
      item_in.second_pump_request = req_second_pump_request;
      item_in.has_servo           = req_has_servo;
      item_in.servo_request_deg   = req_servo_request_deg;

      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      state_in     = advance ? step_nxt : state_ff;
      out_state_in = step_nxt;
      out_evt_in   = step_evt;

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{first_pump: 1'b0, second_pump: 1'b0,
                           silence_count: '0, run_count: '0,
                           lockout: 1'b0, servo_angle: SERVO_MIN_RESET};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         out_state_ff <= out_state_in;
         out_evt_ff   <= out_evt_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_first_pump_on   = out_state_ff.first_pump;
   assign rsp_second_pump_on  = out_state_ff.second_pump;
   assign rsp_servo_angle_deg = out_state_ff.servo_angle;
   assign rsp_lockout_active  = out_state_ff.lockout;
   assign rsp_event_code      = out_evt_ff;

   `PSI_ASSERT_NEXT(a_lockout_sticky, clock, reset, state_ff.lockout, state_ff.lockout, "lockout cleared without reset")
   `PSI_ASSERT_NOW(a_stop_halts, clock, reset, rsp_valid && (rsp_event_code == EV_WATCHDOG || rsp_event_code == EV_RUNTIME), !rsp_first_pump_on && !rsp_second_pump_on, "stop event with a pump still on")
   `PSI_ASSERT_NOW(a_runtime_locks, clock, reset, rsp_valid && rsp_event_code == EV_RUNTIME, rsp_lockout_active, "runtime stop without lockout")
   `PSI_ASSERT_NEXT(a_state_holds, clock, reset, !advance, $stable(state_ff), "state changed with no beat processed")

endmodule

FILE: verif/pump_safety_interlock_checker.sv
// checker for the pump safety interlock: predicts every response beat and compares it
`timescale 1ns / 1ps

module pump_safety_interlock_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_command,
   input  logic                                 req_has_first_pump,
   input  logic                                 req_first_pump_request,
   input  logic                                 req_has_second_pump,
   input  logic                                 req_second_pump_request,
   input  logic                                 req_has_servo,
   input  logic signed [psi_pkg::REQ_DEG_W-1:0] req_servo_request_deg,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic                                 rsp_first_pump_on,
   input  logic                                 rsp_second_pump_on,
   input  logic [psi_pkg::DEG_W-1:0]            rsp_servo_angle_deg,
   input  logic                                 rsp_lockout_active,
   input  logic [psi_pkg::EVT_W-1:0]            rsp_event_code,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [psi_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [psi_pkg::CNT_W-1:0]            csr_wdata,
   output int                                   fail_count,
   output int                                   outstanding
);
   import psi_pkg::*;

   typedef struct packed {
      logic             first_pump;
      logic             second_pump;
      logic [DEG_W-1:0] servo_angle;
      logic             lockout;
      psi_event_type    event_code;
   } pump_status_type;

   psi_cfg_type     limits;
   psi_state_type   plant;
   psi_item_type    req_beat;
   pump_status_type expected_status_q[$];

   assign req_beat = {req_command, req_has_first_pump, req_first_pump_request,
                      req_has_second_pump, req_second_pump_request, req_has_servo,
                      req_servo_request_deg};

   function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
      return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
   endfunction

   function automatic void stop_pumps();
      plant.first_pump  = 1'b0;
      plant.second_pump = 1'b0;
      plant.run_count   = '0;
   endfunction

   // run time restarts when a pump starts from all off, and whenever all are off
   function automatic void switch_pump(input logic pick_second, input logic on);
      logic was_running;
      was_running = plant.first_pump | plant.second_pump;
      if (pick_second) plant.second_pump = on;
      else plant.first_pump = on;
      if ((on && !was_running) || !(plant.first_pump | plant.second_pump))
         plant.run_count = '0;
   endfunction

   function automatic pump_status_type apply_beat(input psi_item_type beat);
      pump_status_type res;
      int deg;
      res.event_code = EV_NONE;
      if (beat.command) begin
         plant.silence_count = '0;
         if (plant.lockout && ((beat.has_first_pump && beat.first_pump_request) ||
                               (beat.has_second_pump && beat.second_pump_request))) begin
            res.event_code = EV_REJECTED;
         end else begin
            if (beat.has_first_pump) switch_pump(1'b0, beat.first_pump_request);
            if (beat.has_second_pump) switch_pump(1'b1, beat.second_pump_request);
            if (beat.has_servo) begin
               deg = int'(beat.servo_request_deg);
               // an inverted range sends values below min to min, all others to max
               if (deg < int'(limits.servo_min)) plant.servo_angle = limits.servo_min;
               else if (deg > int'(limits.servo_max)) plant.servo_angle = limits.servo_max;
               else plant.servo_angle = DEG_W'(deg);
            end
            res.event_code = EV_APPLIED;
         end
      end else begin
         plant.silence_count = count_up(plant.silence_count);
         if (plant.first_pump | plant.second_pump) plant.run_count = count_up(plant.run_count);
         if ((plant.first_pump | plant.second_pump) &&
             plant.silence_count > limits.watchdog_limit) begin
            stop_pumps();
            res.event_code = EV_WATCHDOG;
         end
         // after a watchdog stop nothing runs, so this cannot fire on the same tick
         if ((plant.first_pump | plant.second_pump) &&
             plant.run_count > limits.max_runtime) begin
            plant.lockout = 1'b1;
            stop_pumps();
            res.event_code = EV_RUNTIME;
         end
      end
      res.first_pump  = plant.first_pump;
      res.second_pump = plant.second_pump;
      res.servo_angle = plant.servo_angle;
      res.lockout     = plant.lockout;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      // keep the log short when the block is badly off
      if (fail_count < 40)
         $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : monitor
      pump_status_type want;
      if (reset) begin
         limits.watchdog_limit = WATCHDOG_RESET;
         limits.max_runtime    = RUNTIME_RESET;
         limits.servo_min      = SERVO_MIN_RESET;
         limits.servo_max      = SERVO_MAX_RESET;
         plant                 = '0;
         plant.servo_angle     = SERVO_MIN_RESET;
         expected_status_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (psi_csr_index_type'(csr_index))
               CSR_WATCHDOG_LIMIT: limits.watchdog_limit = csr_wdata;
               CSR_MAX_RUNTIME:    limits.max_runtime    = csr_wdata;
               CSR_SERVO_MIN:      limits.servo_min      = csr_wdata[DEG_W-1:0];
               CSR_SERVO_MAX:      limits.servo_max      = csr_wdata[DEG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_status_q.push_back(apply_beat(req_beat));
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_status_q.size() == 0) begin
               report_mismatch("response beat with nothing expected", 32'd0, 32'd0);
            end else begin
               want = expected_status_q.pop_front();
               if (rsp_first_pump_on !== want.first_pump)
                  report_mismatch("first_pump_on", 32'(want.first_pump),
                                  32'(rsp_first_pump_on));
               if (rsp_second_pump_on !== want.second_pump)
                  report_mismatch("second_pump_on", 32'(want.second_pump),
                                  32'(rsp_second_pump_on));
               if (rsp_servo_angle_deg !== want.servo_angle)
                  report_mismatch("servo_angle_deg", 32'(want.servo_angle),
                                  32'(rsp_servo_angle_deg));
               if (rsp_lockout_active !== want.lockout)
                  report_mismatch("lockout_active", 32'(want.lockout),
                                  32'(rsp_lockout_active));
               if (rsp_event_code !== want.event_code)
                  report_mismatch("event_code", 32'(want.event_code),
                                  32'(rsp_event_code));
            end
         end
      end
      outstanding <= expected_status_q.size();
   end

endmodule

FILE: verif/pump_safety_interlock_core_tb.sv
// testbench top for the pump safety interlock: stimulus, handshakes and verdict
`timescale 1ns / 1ps

module pump_safety_interlock_core_tb;
   import psi_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_command;
   logic                        req_has_first_pump;
   logic                        req_first_pump_request;
   logic                        req_has_second_pump;
   logic                        req_second_pump_request;
   logic                        req_has_servo;
   logic signed [REQ_DEG_W-1:0] req_servo_request_deg;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic                        rsp_first_pump_on;
   logic                        rsp_second_pump_on;
   logic [DEG_W-1:0]            rsp_servo_angle_deg;
   logic                        rsp_lockout_active;
   logic [EVT_W-1:0]            rsp_event_code;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CNT_W-1:0]            csr_wdata;

   int fail_count;
   int outstanding;
   bit gaps_on;
   int stall_left;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pump_safety_interlock_core uut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_command             (req_command),
      .req_has_first_pump      (req_has_first_pump),
      .req_first_pump_request  (req_first_pump_request),
      .req_has_second_pump     (req_has_second_pump),
      .req_second_pump_request (req_second_pump_request),
      .req_has_servo           (req_has_servo),
      .req_servo_request_deg   (req_servo_request_deg),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_first_pump_on       (rsp_first_pump_on),
      .rsp_second_pump_on      (rsp_second_pump_on),
      .rsp_servo_angle_deg     (rsp_servo_angle_deg),
      .rsp_lockout_active      (rsp_lockout_active),
      .rsp_event_code          (rsp_event_code),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   pump_safety_interlock_checker checker_i (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_command             (req_command),
      .req_has_first_pump      (req_has_first_pump),
      .req_first_pump_request  (req_first_pump_request),
      .req_has_second_pump     (req_has_second_pump),
      .req_second_pump_request (req_second_pump_request),
      .req_has_servo           (req_has_servo),
      .req_servo_request_deg   (req_servo_request_deg),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_first_pump_on       (rsp_first_pump_on),
      .rsp_second_pump_on      (rsp_second_pump_on),
      .rsp_servo_angle_deg     (rsp_servo_angle_deg),
      .rsp_lockout_active      (rsp_lockout_active),
      .rsp_event_code          (rsp_event_code),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .fail_count              (fail_count),
      .outstanding             (outstanding)
   );

   // response side: when gaps are on, each accepted beat may be followed by a random stall
   always @(posedge clock) begin : rsp_side
      int hold;
      hold = 0;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else if (rsp_valid && !rsp_stall && gaps_on) begin
         hold = $urandom_range(0, 3);
         stall_left <= hold;
         rsp_stall  <= (hold > 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic psi_cfg_type settings(input int wd, input int rt, input int lo,
                                            input int hi);
      psi_cfg_type c;
      c.watchdog_limit = CNT_W'(wd);
      c.max_runtime    = CNT_W'(rt);
      c.servo_min      = DEG_W'(lo);
      c.servo_max      = DEG_W'(hi);
      return c;
   endfunction

   function automatic psi_item_type make_beat(input int cmd, h1, r1, h2, r2, hs, deg);
      psi_item_type b;
      b.command             = cmd[0];
      b.has_first_pump      = h1[0];
      b.first_pump_request  = r1[0];
      b.has_second_pump     = h2[0];
      b.second_pump_request = r2[0];
      b.has_servo           = hs[0];
      b.servo_request_deg   = REQ_DEG_W'(deg);
      return b;
   endfunction

   // ticks carry random junk in the ignored fields
   function automatic psi_item_type random_beat(input bit tick_only);
      psi_item_type b;
      logic [31:0] r;
      r = $urandom;
      b = r[$bits(psi_item_type)-1:0];
      b.command = !tick_only && ($urandom_range(0, 99) >= 55);
      if (b.command) begin
         b.first_pump_request  = ($urandom_range(0, 9) < 7);
         b.second_pump_request = ($urandom_range(0, 9) < 7);
         if ($urandom_range(0, 4) != 0)
            b.servo_request_deg = REQ_DEG_W'(int'($urandom_range(0, 220)) - 20);
      end
      return b;
   endfunction

   // called in the step of a rising edge; valid stays high across back-to-back beats
   task automatic send_beat(input psi_item_type b);
      int gap;
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_command             <= b.command;
      req_has_first_pump      <= b.has_first_pump;
      req_first_pump_request  <= b.first_pump_request;
      req_has_second_pump     <= b.has_second_pump;
      req_second_pump_request <= b.second_pump_request;
      req_has_servo           <= b.has_servo;
      req_servo_request_deg   <= b.servo_request_deg;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_register(input psi_csr_index_type idx, input logic [CNT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // waits until every response is back, then writes all four registers
   task automatic apply_settings(input psi_cfg_type c, input bit idle);
      logic [31:0] junk;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      junk = $urandom;
      gaps_on <= idle;
      write_register(CSR_WATCHDOG_LIMIT, c.watchdog_limit);
      write_register(CSR_MAX_RUNTIME, c.max_runtime);
      // upper data bits are dont-care for the servo bounds
      write_register(CSR_SERVO_MIN, {junk[CNT_W-DEG_W-1:0], c.servo_min});
      write_register(CSR_SERVO_MAX, {junk[31:32-(CNT_W-DEG_W)], c.servo_max});
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input psi_cfg_type c, input int n_beats, input bit idle);
      int sent;
      int burst;
      int burst_max;
      apply_settings(c, idle);
      // tick bursts long enough to starve the watchdog when its limit is below 20
      burst_max = (c.watchdog_limit < 20) ? int'(c.watchdog_limit) * 2 + 4 : 40;
      sent = 0;
      while (sent < n_beats) begin
         if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, burst_max);
            repeat (burst) send_beat(random_beat(1'b1));
            sent += burst;
         end else begin
            send_beat(random_beat(1'b0));
            sent++;
         end
      end
   endtask

   initial begin : cycle_guard
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      reset                   <= 1'b1;
      req_valid               <= 1'b0;
      req_command             <= 1'b0;
      req_has_first_pump      <= 1'b0;
      req_first_pump_request  <= 1'b0;
      req_has_second_pump     <= 1'b0;
      req_second_pump_request <= 1'b0;
      req_has_servo           <= 1'b0;
      req_servo_request_deg   <= '0;
      csr_valid               <= 1'b0;
      csr_index               <= '0;
      csr_wdata               <= '0;
      gaps_on                 <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle tick, ignored tick fields, empty command, clamp ends, pump switching
      send_beat(make_beat(0, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(0, 1, 1, 1, 1, 1, -1));
      send_beat(make_beat(1, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(1, 0, 0, 0, 0, 1, -1024));
      send_beat(make_beat(1, 0, 0, 0, 0, 1, 1023));
      send_beat(make_beat(1, 0, 0, 0, 0, 1, 180));
      send_beat(make_beat(1, 0, 0, 0, 0, 1, 181));
      send_beat(make_beat(1, 0, 0, 0, 0, 1, 0));
      send_beat(make_beat(1, 1, 1, 0, 0, 0, 0));
      send_beat(make_beat(1, 0, 0, 1, 1, 1, -1));
      send_beat(make_beat(0, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(1, 1, 0, 0, 1, 0, 0));
      send_beat(make_beat(1, 0, 1, 1, 0, 0, 0));

      // zero watchdog limit trips on the first tick
      apply_settings(settings(0, 86400000, 30, 150), 1'b1);
      send_beat(make_beat(1, 1, 1, 1, 1, 1, 29));
      send_beat(make_beat(0, 0, 0, 0, 0, 0, 0));

      // inverted servo range, then watchdog and runtime due on the same tick
      apply_settings(settings(3, 3, 150, 30), 1'b1);
      send_beat(make_beat(1, 0, 0, 0, 0, 1, 100));
      send_beat(make_beat(1, 0, 0, 0, 0, 1, 200));
      send_beat(make_beat(1, 1, 1, 1, 0, 0, 0));
      repeat (4) send_beat(make_beat(0, 0, 0, 0, 0, 0, 0));

      // random part; the lockout is sticky, so short runtime limits come last
      run_phase(settings(5, 86400000, 0, 180), 110, 1'b1);
      run_phase(settings(1, 86400000, 20, 160), 110, 1'b0);
      run_phase(settings(86400000, 86400000, 90, 90), 100, 1'b1);
      run_phase(settings($urandom_range(2, 15), 86400000, $urandom_range(0, 180),
                         $urandom_range(0, 180)), 110, 1'b1);
      run_phase(settings(0, 600000, 180, 0), 100, 1'b1);
      run_phase(settings($urandom_range(3, 12), $urandom_range(200, 400),
                         $urandom_range(0, 180), $urandom_range(0, 180)), 110, 1'b1);
      run_phase(settings($urandom_range(20, 40), 1, $urandom_range(0, 180),
                         $urandom_range(0, 180)), 120, 1'b1);

      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
